// ----- src/urc_pkg.sv -----
// Shared types, constants and unit tables for the ultrasonic range controller.
package urc_pkg;

    localparam int CNT_BITS   = 16;
    localparam int MAGIC_BITS = 27;
    localparam int DIV_SHIFT  = 32;
    localparam int Q_BITS     = CNT_BITS + MAGIC_BITS - DIV_SHIFT;
    localparam int DIST_BITS  = 9;

    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_IDLE_GAP  = 2'd1;
    localparam logic [1:0] CFG_TRIG_WIDE = 2'd2;

    localparam logic [15:0] TIMEOUT_RST   = 16'd30000;
    localparam logic [15:0] IDLE_GAP_RST  = 16'd50000;
    localparam logic [7:0]  TRIG_WIDE_RST = 8'd10;

    localparam logic [1:0] UNIT_CM   = 2'd0;
    localparam logic [1:0] UNIT_M    = 2'd1;
    localparam logic [1:0] UNIT_INCH = 2'd2;
    localparam logic [1:0] UNIT_FEET = 2'd3;

    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef struct packed {
        logic [15:0] timeout_us;
        logic [15:0] idle_gap_us;
        logic [7:0]  trigger_width_us;
    } cfg_t;

    typedef struct packed {
        logic       trigger_level;
        logic       busy_res;
        logic       done_res;
        logic       no_object;
        logic [1:0] unit;
        cnt_t       pulse;
    } meas_t;

    // ceil(2^32 / divisor): exact floor division for any counter value
    function automatic logic [MAGIC_BITS-1:0] unit_magic(input logic [1:0] unit);
        logic [MAGIC_BITS-1:0] m;
        begin
            case (unit)
                UNIT_CM:   m = MAGIC_BITS'(74051161);
                UNIT_M:    m = MAGIC_BITS'(736575);
                UNIT_INCH: m = MAGIC_BITS'(29020050);
                UNIT_FEET: m = MAGIC_BITS'(2415618);
                default:   m = '0;
            endcase
            return m;
        end
    endfunction

    function automatic logic [DIST_BITS-1:0] unit_max(input logic [1:0] unit);
        logic [DIST_BITS-1:0] v;
        begin
            case (unit)
                UNIT_CM:   v = DIST_BITS'(450);
                UNIT_M:    v = DIST_BITS'(5);
                UNIT_INCH: v = DIST_BITS'(178);
                UNIT_FEET: v = DIST_BITS'(15);
                default:   v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- src/urc_cfg_regs.sv -----
// Configuration registers of the ultrasonic range controller.
module urc_cfg_regs
    import urc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TIMEOUT:   cfg_next.timeout_us       = cfg_data;
                CFG_IDLE_GAP:  cfg_next.idle_gap_us      = cfg_data;
                CFG_TRIG_WIDE: cfg_next.trigger_width_us = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_us       <= TIMEOUT_RST;
            cfg_reg.idle_gap_us      <= IDLE_GAP_RST;
            cfg_reg.trigger_width_us <= TRIG_WIDE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/urc_seq.sv -----
// Measurement sequencer: trigger timing, echo timing and the stage register.
module urc_seq
    import urc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       take,
    input  logic       start_req,
    input  logic [1:0] mode,
    input  logic       echo_level,
    input  logic       adv,
    output logic       meas_valid,
    output meas_t      meas
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_GAP  = 3'd1;
    localparam logic [2:0] PH_TRIG = 3'd2;
    localparam logic [2:0] PH_PRE  = 3'd3;
    localparam logic [2:0] PH_WAIT = 3'd4;
    localparam logic [2:0] PH_MEAS = 3'd5;

    logic [2:0] phase_reg, phase_next;
    cnt_t       tick_reg, tick_next;
    cnt_t       elapsed_reg, elapsed_next;
    cnt_t       pulse_reg, pulse_next;
    logic [1:0] unit_reg, unit_next;
    logic       valid_reg, valid_next;
    meas_t      meas_reg, meas_next;

    cnt_t tick_inc;
    cnt_t elapsed_inc;
    cnt_t pulse_inc;
    cnt_t gap_lim;
    cnt_t width_lim;
    cnt_t timeout_lim;
    logic finished;
    logic timed_out;

    assign tick_inc    = (tick_reg == CNT_MAX) ? CNT_MAX : tick_reg + cnt_t'(1);
    assign elapsed_inc = (elapsed_reg == CNT_MAX) ? CNT_MAX : elapsed_reg + cnt_t'(1);
    assign pulse_inc   = (pulse_reg == CNT_MAX) ? CNT_MAX : pulse_reg + cnt_t'(1);
    assign gap_lim     = cnt_t'(cfg.idle_gap_us);
    assign width_lim   = cnt_t'(cfg.trigger_width_us);
    assign timeout_lim = cnt_t'(cfg.timeout_us);

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        elapsed_next = elapsed_reg;
        pulse_next   = pulse_reg;
        unit_next    = unit_reg;
        finished     = 1'b0;
        timed_out    = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    unit_next  = mode;
                    tick_next  = '0;
                    phase_next = (cfg.idle_gap_us == 16'd0) ? PH_TRIG : PH_GAP;
                end
            end
            PH_GAP:
            begin
                tick_next = tick_inc;
                if (tick_inc >= gap_lim || tick_inc == CNT_MAX)
                begin
                    tick_next  = '0;
                    phase_next = PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                tick_next = tick_inc;
                if (tick_inc >= width_lim || tick_inc == CNT_MAX)
                begin
                    tick_next    = '0;
                    elapsed_next = '0;
                    pulse_next   = '0;
                    phase_next   = PH_PRE;
                end
            end
            default:
            begin
                elapsed_next = elapsed_inc;
                if (phase_reg == PH_PRE)
                begin
                    if (!echo_level)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                else if (phase_reg == PH_WAIT)
                begin
                    if (echo_level)
                    begin
                        pulse_next = cnt_t'(1);
                        phase_next = PH_MEAS;
                    end
                end
                else
                begin
                    if (echo_level)
                    begin
                        pulse_next = pulse_inc;
                    end
                    else
                    begin
                        finished = 1'b1;
                    end
                end
                if (elapsed_inc >= timeout_lim || elapsed_inc == CNT_MAX)
                begin
                    finished  = 1'b1;
                    timed_out = 1'b1;
                end
                if (finished)
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        meas_next.trigger_level = (phase_next == PH_TRIG);
        meas_next.busy_res      = (phase_next != PH_IDLE);
        meas_next.done_res      = finished;
        meas_next.no_object     = timed_out;
        meas_next.unit          = unit_next;
        meas_next.pulse         = pulse_next;
        valid_next = take | (valid_reg & ~adv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            elapsed_reg <= '0;
            pulse_reg   <= '0;
            unit_reg    <= UNIT_CM;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                elapsed_reg <= elapsed_next;
                pulse_reg   <= pulse_next;
                unit_reg    <= unit_next;
            end
        end
    end

    // hold the word until the scaling stage takes it
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            meas_reg <= meas_next;
        end
    end

    assign meas_valid = valid_reg;
    assign meas       = meas_reg;

endmodule

// ----- src/urc_scale.sv -----
// Unit scaling and clamp of the pulse width, with the result register.
module urc_scale
    import urc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 meas_valid,
    input  meas_t                meas,
    output logic                 out_valid,
    output logic                 trigger_level,
    output logic                 busy_res,
    output logic                 done_res,
    output logic                 no_object,
    output logic [DIST_BITS-1:0] distance
);

    logic [CNT_BITS+MAGIC_BITS-1:0] prod;
    logic [Q_BITS-1:0]              quot;
    logic [DIST_BITS-1:0]           lim;
    logic [DIST_BITS-1:0]           dist_next;
    logic                           valid_reg;
    logic                           trigger_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic                           no_obj_reg;
    logic [DIST_BITS-1:0]           dist_reg;

    assign prod = (CNT_BITS+MAGIC_BITS)'(meas.pulse)
                * (CNT_BITS+MAGIC_BITS)'(unit_magic(meas.unit));
    assign quot = prod[CNT_BITS+MAGIC_BITS-1:DIV_SHIFT];
    assign lim  = unit_max(meas.unit);

    always_comb
    begin
        dist_next = '0;
        if (meas.done_res && !meas.no_object)
        begin
            if (quot > Q_BITS'(lim))
            begin
                dist_next = lim;
            end
            else
            begin
                dist_next = quot[DIST_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= meas_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && meas_valid)
        begin
            trigger_reg <= meas.trigger_level;
            busy_reg    <= meas.busy_res;
            done_reg    <= meas.done_res;
            no_obj_reg  <= meas.no_object;
            dist_reg    <= dist_next;
        end
    end

    assign out_valid     = valid_reg;
    assign trigger_level = trigger_reg;
    assign busy_res      = busy_reg;
    assign done_res      = done_reg;
    assign no_object     = no_obj_reg;
    assign distance      = dist_reg;

endmodule

// ----- src/ultrasonic_range_controller.sv -----
// Ultrasonic range controller: one input word per microsecond tick, one result word per input word.
// Every accepted input word produces exactly one result word, via the sequencer stage register and
// the result register; a new word is taken in every cycle while out_ready is high, and both
// registers hold their words when the output stalls. On a start request while idle the block
// latches the unit, holds trigger low for idle_gap_us ticks, high for trigger_width_us ticks, then
// times the echo pulse. A result word with done_res high carries either no_object (timeout) or the
// distance, the pulse width divided by 58, 5831, 148 or 1778 and clamped to 450, 5, 178 or 15.
// Write configuration only while idle.
module ultrasonic_range_controller
    import urc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 start_req,
    input  logic [1:0]           mode,
    input  logic                 echo_level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 trigger_level,
    output logic                 busy_res,
    output logic                 done_res,
    output logic                 no_object,
    output logic [DIST_BITS-1:0] distance
);

    cfg_t  cfg;
    meas_t meas;
    logic  meas_valid;
    logic  adv_out;
    logic  adv_mid;
    logic  take;

    assign adv_out  = ~out_valid | out_ready;
    assign adv_mid  = ~meas_valid | adv_out;
    assign in_ready = adv_mid;
    assign take     = in_valid & adv_mid;

    urc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    urc_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .take       (take),
        .start_req  (start_req),
        .mode       (mode),
        .echo_level (echo_level),
        .adv        (adv_out),
        .meas_valid (meas_valid),
        .meas       (meas)
    );

    urc_scale u_scale
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv_out),
        .meas_valid    (meas_valid),
        .meas          (meas),
        .out_valid     (out_valid),
        .trigger_level (trigger_level),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .no_object     (no_object),
        .distance      (distance)
    );

endmodule
